// ----- hdl/iibf_pkg.sv -----
// shared constants and types of the integral image box filter
package iibf_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_WINDOW  = 16;
    localparam int RING_ROWS   = MAX_WINDOW + 1;
    localparam int COL_BITS    = 10;
    localparam int ROW_BITS    = 10;
    localparam int SLOT_BITS   = 5;
    localparam int DIM_BITS    = 11;
    localparam int WIN_BITS    = 5;
    localparam int SEL_BITS    = 4;
    localparam int RECIP_BITS  = 17;
    localparam int ROWSUM_BITS = 18;
    localparam int INTEG_BITS  = 28;
    localparam int PROD_BITS   = INTEG_BITS + RECIP_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int RAM_DEPTH   = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_BITS   = 15;
    localparam int CFG_BITS    = 17;
    localparam int IDX_BITS    = 2;

    localparam logic [IDX_BITS-1:0] CFG_FRAME_WIDTH       = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_FRAME_HEIGHT      = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_WINDOW_SIZE       = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_WINDOW_RECIPROCAL = 2'd3;

    localparam logic [DIM_BITS-1:0]   RST_FRAME_WIDTH       = 11'd640;
    localparam logic [DIM_BITS-1:0]   RST_FRAME_HEIGHT      = 11'd480;
    localparam logic [WIN_BITS-1:0]   RST_WINDOW_SIZE       = 5'd3;
    localparam logic [RECIP_BITS-1:0] RST_WINDOW_RECIPROCAL = 17'd7282;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(RING_ROWS - 1);
    localparam logic [7:0]           PIX_MAX   = 8'd255;

    typedef struct packed {
        logic [DIM_BITS-1:0]   frame_width;
        logic [DIM_BITS-1:0]   frame_height;
        logic [WIN_BITS-1:0]   window_size;
        logic [RECIP_BITS-1:0] window_reciprocal;
    } cfg_t;

    typedef struct packed {
        logic [ROWSUM_BITS-1:0] rowsum;
        logic                   use_above;
        logic                   use_back;
        logic                   use_left;
        logic                   use_diag;
        logic                   win_zero;
        logic [SEL_BITS-1:0]    win_sel;
        logic [ADDR_BITS-1:0]   wr_addr;
    } front_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] above_addr;
        logic [ADDR_BITS-1:0] back_addr;
        logic [ADDR_BITS-1:0] diag_addr;
    } ring_rd_t;

endpackage

// ----- hdl/iibf_pixel_if.sv -----
// pixel request channel
interface iibf_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [iibf_pkg::PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

// ----- hdl/iibf_result_if.sv -----
// smoothed result request channel
interface iibf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] smoothed_value;

    modport source (output valid, output smoothed_value, input ready);
    modport sink (input valid, input smoothed_value, output ready);
endinterface

// ----- hdl/integral_image_box_filter.sv -----
// box filter top level: config registers, ring memories and pipeline control
//
// Takes one pixel per clock in raster order unless result back-pressure stalls
// the pipeline, and returns the mean of the trailing s-by-s window for each
// pixel. The pipeline is four stages: address generation and ring read, integral
// value and ring write-back, window sum and reciprocal multiply, saturation into
// the output register. The summed-area ring of 17 rows of 1024 entries is held
// in three identical copies, one per read port (row above, window top row, window
// top-left corner), each taking one read and one write per clock. Reads of the
// row above and the window top row that hit the entry written back in the same
// clock take the written value instead of the memory output. The window left
// edge comes from a shift line of recent integral values. The ring needs no
// clearing after reset. Stages advance independently, so bubbles close up and a
// new pixel is taken while a result waits at the output.
module integral_image_box_filter import iibf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    iibf_pixel_if.sink          pixel,
    iibf_result_if.source       result,
    input  logic                cfg_write,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_t     cfg_reg;
    front_t   front;
    ring_rd_t ring_rd;

    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic en1, en2, en3, en4, acc, ld2, ld3, ld4;

    logic                  ring_we;
    logic [ADDR_BITS-1:0]  ring_wr_addr;
    logic [INTEG_BITS-1:0] ring_wr_data, above_data, back_data, diag_data, window_sum;

    logic                  fwd_above_reg, fwd_back_reg;
    logic [INTEG_BITS-1:0] fwd_data_reg, above_eff, back_eff;

    always_comb
    begin
        en4 = !ov_reg || result.ready;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
        acc = pixel.valid && en1;
        ld2 = v1_reg && en2;
        ld3 = v2_reg && en3;
        ld4 = v3_reg && en4;
    end

    assign pixel.ready  = en1;
    assign result.valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= acc;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                ov_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width       <= RST_FRAME_WIDTH;
            cfg_reg.frame_height      <= RST_FRAME_HEIGHT;
            cfg_reg.window_size       <= RST_WINDOW_SIZE;
            cfg_reg.window_reciprocal <= RST_WINDOW_RECIPROCAL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:       cfg_reg.frame_width       <= cfg_data[DIM_BITS-1:0];
                CFG_FRAME_HEIGHT:      cfg_reg.frame_height      <= cfg_data[DIM_BITS-1:0];
                CFG_WINDOW_SIZE:       cfg_reg.window_size       <= cfg_data[WIN_BITS-1:0];
                CFG_WINDOW_RECIPROCAL: cfg_reg.window_reciprocal <= cfg_data[RECIP_BITS-1:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // read of the entry being written back in the same clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_above_reg <= 1'b0;
            fwd_back_reg  <= 1'b0;
        end
        else if (acc)
        begin
            fwd_above_reg <= ring_we && (ring_rd.above_addr == ring_wr_addr);
            fwd_back_reg  <= ring_we && (ring_rd.back_addr == ring_wr_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fwd_data_reg <= ring_wr_data;
        end
    end

    assign above_eff = fwd_above_reg ? fwd_data_reg : above_data;
    assign back_eff  = fwd_back_reg ? fwd_data_reg : back_data;

    iibf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (acc),
        .pixel_value (pixel.pixel_value),
        .front       (front),
        .ring_rd     (ring_rd)
    );

    iibf_ram #(.DEPTH(RAM_DEPTH), .WIDTH(INTEG_BITS), .AW(ADDR_BITS)) u_ring_above (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (acc),
        .rd_addr (ring_rd.above_addr),
        .rd_data (above_data)
    );

    iibf_ram #(.DEPTH(RAM_DEPTH), .WIDTH(INTEG_BITS), .AW(ADDR_BITS)) u_ring_back (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (acc),
        .rd_addr (ring_rd.back_addr),
        .rd_data (back_data)
    );

    iibf_ram #(.DEPTH(RAM_DEPTH), .WIDTH(INTEG_BITS), .AW(ADDR_BITS)) u_ring_diag (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (acc),
        .rd_addr (ring_rd.diag_addr),
        .rd_data (diag_data)
    );

    iibf_sum u_sum (
        .clk          (clk),
        .load1        (acc),
        .load2        (ld2),
        .front        (front),
        .above_data   (above_eff),
        .back_data    (back_eff),
        .diag_data    (diag_data),
        .ring_we      (ring_we),
        .ring_wr_addr (ring_wr_addr),
        .ring_wr_data (ring_wr_data),
        .window_sum   (window_sum)
    );

    iibf_scale u_scale (
        .clk            (clk),
        .load3          (ld3),
        .load4          (ld4),
        .window_sum     (window_sum),
        .reciprocal     (cfg_reg.window_reciprocal),
        .smoothed_value (result.smoothed_value)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> v1_reg)
        else $error("accepted pixel did not enter the pipeline");

    a_no_diag_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_we && acc && front.use_diag) |-> (ring_rd.diag_addr != ring_wr_addr))
        else $error("ring read of the window corner collides with write-back");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(v3_reg))
        else $error("result appeared without a multiply stage item");

endmodule

// ----- hdl/iibf_ram.sv -----
// generic single-port-write, single-port-read synchronous ram
module iibf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/iibf_front.sv -----
// raster position counters, row running sum and ring address generation
module iibf_front import iibf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  accept,
    input  logic [PIXEL_BITS-1:0] pixel_value,
    output front_t                front,
    output ring_rd_t              ring_rd
);

    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [ROWSUM_BITS-1:0] rowsum_reg;

    logic [DIM_BITS-1:0]    w_eff, h_eff, col_inc, row_inc;
    logic [WIN_BITS-1:0]    s_eff;
    logic [ROWSUM_BITS-1:0] rowsum_new;
    logic [SLOT_BITS-1:0]   slot_above, slot_back;
    logic [SLOT_BITS:0]     slot_wrap;
    logic [COL_BITS-1:0]    col_left;
    logic                   has_win, row_ok, col_ok;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = DIM_BITS'(1);
        else if (cfg.frame_width > DIM_BITS'(MAX_WIDTH))
            w_eff = DIM_BITS'(MAX_WIDTH);
        else
            w_eff = cfg.frame_width;

        if (cfg.frame_height == '0)
            h_eff = DIM_BITS'(1);
        else if (cfg.frame_height > DIM_BITS'(MAX_HEIGHT))
            h_eff = DIM_BITS'(MAX_HEIGHT);
        else
            h_eff = cfg.frame_height;

        if (cfg.window_size > WIN_BITS'(MAX_WINDOW))
            s_eff = WIN_BITS'(MAX_WINDOW);
        else
            s_eff = cfg.window_size;
    end

    always_comb
    begin
        if (col_reg == '0)
            rowsum_new = ROWSUM_BITS'(pixel_value);
        else
            rowsum_new = rowsum_reg + ROWSUM_BITS'(pixel_value);

        has_win = (s_eff != '0);
        row_ok  = has_win && ({{(ROW_BITS-WIN_BITS){1'b0}}, s_eff} <= row_reg);
        col_ok  = has_win && ({{(COL_BITS-WIN_BITS){1'b0}}, s_eff} <= col_reg);

        slot_above = (slot_reg == '0) ? LAST_SLOT : slot_reg - SLOT_BITS'(1);
        slot_wrap  = {1'b0, slot_reg} + (SLOT_BITS+1)'(RING_ROWS) - {1'b0, s_eff};
        if (slot_reg >= s_eff)
            slot_back = slot_reg - s_eff;
        else
            slot_back = slot_wrap[SLOT_BITS-1:0];
        col_left = col_reg - {{(COL_BITS-WIN_BITS){1'b0}}, s_eff};

        front.rowsum    = rowsum_new;
        front.use_above = (row_reg != '0);
        front.use_back  = row_ok;
        front.use_left  = col_ok;
        front.use_diag  = row_ok && col_ok;
        front.win_zero  = !has_win;
        front.win_sel   = SEL_BITS'(s_eff - WIN_BITS'(1));
        front.wr_addr   = {slot_reg, col_reg};

        ring_rd.above_addr = {slot_above, col_reg};
        ring_rd.back_addr  = {slot_back, col_reg};
        ring_rd.diag_addr  = {slot_back, col_left};
    end

    // raster advance with row and frame wrap
    always_comb
    begin
        col_inc   = {1'b0, col_reg} + DIM_BITS'(1);
        row_inc   = {1'b0, row_reg} + DIM_BITS'(1);
        col_next  = col_inc[COL_BITS-1:0];
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_inc >= w_eff)
        begin
            col_next  = '0;
            row_next  = row_inc[ROW_BITS-1:0];
            slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_BITS'(1);
            if (row_inc >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
            rowsum_reg <= '0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            rowsum_reg <= rowsum_new;
        end
    end

endmodule

// ----- hdl/iibf_sum.sv -----
// integral value, ring write-back and window sum from four corners
module iibf_sum import iibf_pkg::*; (
    input  logic                  clk,
    input  logic                  load1,
    input  logic                  load2,
    input  front_t                front,
    input  logic [INTEG_BITS-1:0] above_data,
    input  logic [INTEG_BITS-1:0] back_data,
    input  logic [INTEG_BITS-1:0] diag_data,
    output logic                  ring_we,
    output logic [ADDR_BITS-1:0]  ring_wr_addr,
    output logic [INTEG_BITS-1:0] ring_wr_data,
    output logic [INTEG_BITS-1:0] window_sum
);

    front_t                f1_reg;
    logic [INTEG_BITS-1:0] taps_reg [0:MAX_WINDOW-1];
    logic [INTEG_BITS-1:0] here_reg, part_reg, left_reg;
    logic                  zero_reg;

    logic [INTEG_BITS-1:0] here, part, left;

    always_comb
    begin
        here = {{(INTEG_BITS-ROWSUM_BITS){1'b0}}, f1_reg.rowsum}
             + (f1_reg.use_above ? above_data : '0);
        part = (f1_reg.use_diag ? diag_data : '0) - (f1_reg.use_back ? back_data : '0);
        left = f1_reg.use_left ? taps_reg[f1_reg.win_sel] : '0;
        window_sum = zero_reg ? '0 : here_reg + part_reg - left_reg;
    end

    assign ring_we      = load2;
    assign ring_wr_addr = f1_reg.wr_addr;
    assign ring_wr_data = here;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            f1_reg <= front;
        end
        if (load2)
        begin
            here_reg    <= here;
            part_reg    <= part;
            left_reg    <= left;
            zero_reg    <= f1_reg.win_zero;
            // recent integral values, newest in tap 0
            taps_reg[0] <= here;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
    end

endmodule

// ----- hdl/iibf_scale.sv -----
// reciprocal multiply, truncation and saturation to a pixel
module iibf_scale import iibf_pkg::*; (
    input  logic                  clk,
    input  logic                  load3,
    input  logic                  load4,
    input  logic [INTEG_BITS-1:0] window_sum,
    input  logic [RECIP_BITS-1:0] reciprocal,
    output logic [7:0]            smoothed_value
);

    logic [PROD_BITS-1:0] prod_reg;
    logic [7:0]           value_reg;

    assign smoothed_value = value_reg;

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            prod_reg <= PROD_BITS'(window_sum) * PROD_BITS'(reciprocal);
        end
        if (load4)
        begin
            if (|prod_reg[PROD_BITS-1:FRAC_BITS+8])
                value_reg <= PIX_MAX;
            else
                value_reg <= prod_reg[FRAC_BITS+7:FRAC_BITS];
        end
    end

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the integral image box filter, predicted window means vs result stream
`timescale 1ns / 100ps
module testbench;
    import iibf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {PIX_RANDOM, PIX_FULL, PIX_DARK, PIX_CHECKER} pix_pattern_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_write = 1'b0;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;

    iibf_pixel_if  pixel_ch ();
    iibf_result_if result_ch ();

    integral_image_box_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    cfg_t                  shadow_cfg;
    logic [INTEG_BITS-1:0] integ_ring [RING_ROWS][MAX_WIDTH];
    logic [INTEG_BITS-1:0] row_acc;
    logic [COL_BITS-1:0]   col_pos;
    logic [ROW_BITS-1:0]   row_pos;
    logic [SLOT_BITS-1:0]  ring_slot;
    logic [7:0]            mean_q [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int src_idle    = 0;
    int sink_idle   = 0;
    int result_hold = 0;

    always #2 clk = ~clk;

    function automatic int clamp_dim(input logic [DIM_BITS-1:0] v, input int limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return int'(v);
    endfunction

    function automatic logic [7:0] predict_mean(input logic [7:0] pix);
        int                    w;
        int                    h;
        int                    s;
        int                    x;
        int                    y;
        int                    cur;
        int                    back;
        logic [INTEG_BITS-1:0] here;
        logic [INTEG_BITS-1:0] sum;
        longint unsigned       prod;
        w = clamp_dim(shadow_cfg.frame_width, MAX_WIDTH);
        h = clamp_dim(shadow_cfg.frame_height, MAX_HEIGHT);
        s = (shadow_cfg.window_size > MAX_WINDOW) ? MAX_WINDOW : int'(shadow_cfg.window_size);
        x = col_pos;
        y = row_pos;
        cur = ring_slot;
        row_acc = ((x == 0) ? INTEG_BITS'(0) : row_acc) + INTEG_BITS'(pix);
        here = row_acc;
        if (y > 0)
        begin
            here = here + integ_ring[(cur + RING_ROWS - 1) % RING_ROWS][x];
        end
        integ_ring[cur][x] = here;
        sum = '0;
        if (s > 0)
        begin
            back = (cur + RING_ROWS - s) % RING_ROWS;
            sum = here;
            if (x >= s && y >= s)
            begin
                sum = sum + integ_ring[back][x - s];
            end
            if (x >= s)
            begin
                sum = sum - integ_ring[cur][x - s];
            end
            if (y >= s)
            begin
                sum = sum - integ_ring[back][x];
            end
        end
        prod = (longint'(sum) * longint'(shadow_cfg.window_reciprocal)) >> FRAC_BITS;
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            cur = (cur + 1) % RING_ROWS;
            if (y >= h)
            begin
                y = 0;
                cur = 0;
            end
        end
        col_pos = COL_BITS'(x);
        row_pos = ROW_BITS'(y);
        ring_slot = SLOT_BITS'(cur);
        return (prod > 255) ? PIX_MAX : 8'(prod);
    endfunction

    function automatic logic [7:0] pattern_pixel(input pix_pattern_t pattern, input int i);
        case (pattern)
            PIX_FULL:    return PIX_MAX;
            PIX_DARK:    return 8'h00;
            PIX_CHECKER: return (i % 2) ? PIX_MAX : 8'h00;
            default:     return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] value);
        while ($urandom_range(99) < src_idle)
        begin
            pixel_ch.valid = 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid = 1'b1;
        pixel_ch.pixel_value = value;
        do @(posedge clk); while (!pixel_ch.ready);
        mean_q.push_back(predict_mean(value));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pixel_ch.valid = 1'b0;
        while (mean_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    // unused upper data bits get random values
    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int value);
        logic [CFG_BITS-1:0] junk;
        junk = CFG_BITS'($urandom);
        cfg_index = idx;
        case (idx)
            CFG_FRAME_WIDTH:
            begin
                cfg_data = {junk[CFG_BITS-1:DIM_BITS], DIM_BITS'(value)};
                shadow_cfg.frame_width = DIM_BITS'(value);
            end
            CFG_FRAME_HEIGHT:
            begin
                cfg_data = {junk[CFG_BITS-1:DIM_BITS], DIM_BITS'(value)};
                shadow_cfg.frame_height = DIM_BITS'(value);
            end
            CFG_WINDOW_SIZE:
            begin
                cfg_data = {junk[CFG_BITS-1:WIN_BITS], WIN_BITS'(value)};
                shadow_cfg.window_size = WIN_BITS'(value);
            end
            default:
            begin
                cfg_data = RECIP_BITS'(value);
                shadow_cfg.window_reciprocal = RECIP_BITS'(value);
            end
        endcase
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic run_frames(input int width, input int height, input int win, input int recip,
                              input int frames, input pix_pattern_t pattern);
        int count;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_WINDOW_SIZE, win);
        write_reg(CFG_WINDOW_RECIPROCAL, recip);
        count = frames * clamp_dim(DIM_BITS'(width), MAX_WIDTH)
                       * clamp_dim(DIM_BITS'(height), MAX_HEIGHT);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(pattern_pixel(pattern, i));
        end
    endtask

    // window size and reciprocal keep their reset values
    task automatic test_reset_window();
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 5);
        write_reg(CFG_FRAME_HEIGHT, 4);
        for (int i = 0; i < 20; i++)
        begin
            send_pixel(pattern_pixel((i < 10) ? PIX_FULL : PIX_RANDOM, i));
        end
    endtask

    task automatic test_degenerate_sizes();
        run_frames(0, 0, 1, 65536, 2, PIX_FULL);
        run_frames(0, 3, 2, 16384, 1, PIX_CHECKER);
        run_frames(4, 0, 1, 65536, 1, PIX_RANDOM);
    endtask

    task automatic test_window_extremes();
        run_frames(4, 2, 0, 65536, 1, PIX_FULL);
        run_frames(6, 3, 31, 256, 1, PIX_FULL);
        run_frames(5, 2, 1, 65536, 1, PIX_RANDOM);
    endtask

    task automatic test_reciprocal_extremes();
        run_frames(3, 2, 2, 0, 1, PIX_FULL);
        run_frames(3, 2, 2, 131071, 1, PIX_CHECKER);
        run_frames(3, 3, 2, 65536, 1, PIX_DARK);
    endtask

    task automatic test_clamped_dimensions();
        run_frames(1, 2047, 16, 256, 1, PIX_RANDOM);
    endtask

    // result side held off so the pipeline fills and stalls pixel requests
    task automatic test_backpressure();
        wait_drained();
        result_hold = 400;
        run_frames(16, 12, 4, 4096, 1, PIX_RANDOM);
    endtask

    task automatic test_random_frames(input int target);
        int           sent;
        int           w;
        int           h;
        int           s;
        int           seff;
        int           r;
        int           frames;
        pix_pattern_t pattern;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(9))
                0:       s = 0;
                1:       s = $urandom_range(31, 16);
                2:       s = $urandom_range(15, 9);
                default: s = $urandom_range(8, 1);
            endcase
            seff = (s > MAX_WINDOW) ? MAX_WINDOW : s;
            if (seff > 8)
            begin
                w = $urandom_range(seff + 6, seff);
                h = $urandom_range(seff + 3, seff);
                frames = 1;
            end
            else if ($urandom_range(5) == 0)
            begin
                w = $urandom_range(300, 1);
                h = $urandom_range(2, 1);
                frames = 1;
            end
            else
            begin
                w = $urandom_range(16, 1);
                h = $urandom_range(20, 1);
                frames = $urandom_range(3, 1);
            end
            if (w == 1 && $urandom_range(1) == 1)
            begin
                w = 0;
            end
            if (h == 1 && $urandom_range(1) == 1)
            begin
                h = 0;
            end
            case ($urandom_range(7))
                0:       r = $urandom_range(131071, 0);
                1:       r = 65536;
                default: r = (seff == 0) ? $urandom_range(131071, 0)
                                         : 65536 / (seff * seff) + $urandom_range(1, 0);
            endcase
            case ($urandom_range(9))
                0:       pattern = PIX_FULL;
                1:       pattern = PIX_CHECKER;
                2:       pattern = PIX_DARK;
                default: pattern = PIX_RANDOM;
            endcase
            run_frames(w, h, s, r, frames, pattern);
            sent += frames * clamp_dim(DIM_BITS'(w), MAX_WIDTH) * clamp_dim(DIM_BITS'(h), MAX_HEIGHT);
        end
    endtask

    always @(negedge clk)
    begin
        if (result_hold > 0)
        begin
            result_ch.ready = 1'b0;
            result_hold = result_hold - 1;
        end
        else
        begin
            result_ch.ready = ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (mean_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("smoothed value %0d arrived with none expected",
                             result_ch.smoothed_value);
                end
            end
            else
            begin
                want = mean_q.pop_front();
                if (result_ch.smoothed_value !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("smoothed value: expected %0d, got %0d",
                                 want, result_ch.smoothed_value);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("integral_image_box_filter: mismatch");
            $finish;
        end
    end

    initial
    begin
        shadow_cfg = {RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_WINDOW_SIZE, RST_WINDOW_RECIPROCAL};
        row_acc = '0;
        col_pos = '0;
        row_pos = '0;
        ring_slot = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel_value = '0;
        result_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_idle = 32;
        sink_idle = 59;
        test_reset_window();
        test_degenerate_sizes();
        test_window_extremes();
        test_reciprocal_extremes();
        test_random_frames(100);

        src_idle = 59;
        sink_idle = 32;
        test_clamped_dimensions();

        src_idle = 0;
        sink_idle = 0;
        test_backpressure();
        test_random_frames(50);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && mean_q.size() == 0)
        begin
            $display("integral_image_box_filter: match");
        end
        else
        begin
            $display("integral_image_box_filter: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/iibf_pkg.sv
hdl/iibf_pixel_if.sv
hdl/iibf_result_if.sv
hdl/iibf_ram.sv
hdl/iibf_front.sv
hdl/iibf_sum.sv
hdl/iibf_scale.sv
hdl/integral_image_box_filter.sv
sim/testbench.sv
